FILE: hw/rtl/bbc_pkg.sv
// Shared constants and types for the balanced bracket counter.
`timescale 1ns / 1ps
package bbc_pkg;

   // Widths, modulus, its multiples and Fermat exponent used for the inverse
   localparam int unsigned MUL_W = 30;
   localparam int unsigned CNT_W = 5;
   localparam int unsigned SUM_W = 32;

   localparam logic [MUL_W-1:0] PRIME_MOD  = 30'd1000000007;
   localparam logic [MUL_W-1:0] FERMAT_EXP = 30'd1000000005;
   localparam logic [SUM_W-1:0] PRIME_X1   = 32'd1000000007;
   localparam logic [SUM_W-1:0] PRIME_X2   = 32'd2000000014;

   // Start command for the bit-serial modular multiplier
   typedef struct packed {
      logic             start;
      logic [CNT_W-1:0] nbits;
   } mm_cmd_type;

endpackage

FILE: hw/rtl/bbc_modmul.sv
// Bit-serial modular multiplier: one bit of the second operand per cycle, MSB first.
`timescale 1ns / 1ps
module bbc_modmul (
   input  logic                      clock,
   input  logic                      reset,
   input  bbc_pkg::mm_cmd_type       cmd,
   input  logic [bbc_pkg::MUL_W-1:0] op_a,
   input  logic [bbc_pkg::MUL_W-1:0] op_b,
   output logic [bbc_pkg::MUL_W-1:0] result,
   output logic                      busy
);
   import bbc_pkg::*;

   logic [MUL_W-1:0] a_ff, a_in;
   logic [MUL_W-1:0] b_ff, b_in;
   logic [MUL_W-1:0] acc_ff, acc_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic [SUM_W-1:0] sum;

   // Double and add, then fold back below the modulus
   always_comb begin
      sum = {1'b0, acc_ff, 1'b0} + (b_ff[MUL_W-1] ? {2'b00, a_ff} : '0);
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (cmd.start) begin
         a_in    = op_a;
         b_in    = op_b << (CNT_W'(MUL_W) - cmd.nbits);
         acc_in  = '0;
         cnt_in  = cmd.nbits;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (sum >= PRIME_X2) begin
            acc_in = MUL_W'(sum - PRIME_X2);
         end else if (sum >= PRIME_X1) begin
            acc_in = MUL_W'(sum - PRIME_X1);
         end else begin
            acc_in = MUL_W'(sum);
         end
         b_in   = b_ff << 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

   assign result = acc_ff;
   assign busy   = busy_ff;

endmodule

FILE: hw/rtl/balanced_bracket_count_mod_prime_top.sv
// Top level: Catalan number of a bracket-sequence length modulo 1000000007.
// For length 2k the block runs k+1 steps of two parallel W-bit serial multipliers
//   (W = bits of the length port), then 46 multiplies for the Fermat inverse and the final product.
// Odd or out-of-range lengths go straight to the done state and return a count of zero.
// Throughput: one transaction at a time; a new request is taken once the result is queued.
// Reset: synchronous, active high; clears the sequencer and the response valid.
`timescale 1ns / 1ps
module balanced_bracket_count_mod_prime_top #(
   parameter int unsigned MAX_LENGTH = 2097152,
   localparam int unsigned LEN_W     = $clog2(MAX_LENGTH + 1)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [LEN_W-1:0]          req_sequence_length,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [bbc_pkg::MUL_W-1:0] rsp_sequence_count
);
   import bbc_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE, ST_PROD, ST_PROD_WAIT, ST_SQ, ST_SQ_WAIT,
      ST_MUL, ST_MUL_WAIT, ST_FIN, ST_FIN_WAIT, ST_DONE
   } state_type;

   state_type        state_ff, state_in;
   logic [LEN_W-1:0] k_ff, k_in;
   logic [LEN_W-1:0] j_ff, j_in;
   logic [CNT_W-1:0] e_ff, e_in;
   logic [MUL_W-1:0] num_ff, num_in;
   logic [MUL_W-1:0] den_ff, den_in;
   logic [MUL_W-1:0] inv_ff, inv_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [MUL_W-1:0] rsp_count_ff, rsp_count_in;

   mm_cmd_type       cmd0, cmd1;
   logic [MUL_W-1:0] a0, b0, a1, b1, res0, res1;
   logic             busy0, busy1;
   logic [LEN_W-1:0] num_factor;
   logic             len_ok;

   bbc_modmul u_mul0 (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd0),
      .op_a   (a0),
      .op_b   (b0),
      .result (res0),
      .busy   (busy0)
   );

   bbc_modmul u_mul1 (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd1),
      .op_a   (a1),
      .op_b   (b1),
      .result (res1),
      .busy   (busy1)
   );

   // Numerator runs k+1..2k, then multiplies by one on the extra denominator step
   assign num_factor = (j_ff <= k_ff) ? LEN_W'(k_ff + j_ff) : LEN_W'(1);
   assign len_ok     = (req_sequence_length <= LEN_W'(MAX_LENGTH))
                       && !req_sequence_length[0];

   // Sequence the product, inverse and final multiply
   always_comb begin
      state_in     = state_ff;
      k_in         = k_ff;
      j_in         = j_ff;
      e_in         = e_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      inv_in       = inv_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_count_in = rsp_count_ff;
      cmd0         = '{start: 1'b0, nbits: CNT_W'(MUL_W)};
      cmd1         = '{start: 1'b0, nbits: CNT_W'(LEN_W)};
      a0           = inv_ff;
      b0           = inv_ff;
      a1           = den_ff;
      b1           = MUL_W'(j_ff);

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               k_in   = req_sequence_length >> 1;
               j_in   = LEN_W'(1);
               num_in = MUL_W'(1);
               den_in = MUL_W'(1);
               if (len_ok) begin
                  state_in = ST_PROD;
               end else begin
                  num_in   = '0;
                  state_in = ST_DONE;
               end
            end
         end
         ST_PROD: begin
            cmd0     = '{start: 1'b1, nbits: CNT_W'(LEN_W)};
            cmd1     = '{start: 1'b1, nbits: CNT_W'(LEN_W)};
            a0       = num_ff;
            b0       = MUL_W'(num_factor);
            state_in = ST_PROD_WAIT;
         end
         ST_PROD_WAIT: begin
            if (!busy0 && !busy1) begin
               num_in = res0;
               den_in = res1;
               if (j_ff == LEN_W'(k_ff + 1'b1)) begin
                  inv_in   = MUL_W'(1);
                  e_in     = CNT_W'(MUL_W - 1);
                  state_in = ST_SQ;
               end else begin
                  j_in     = j_ff + 1'b1;
                  state_in = ST_PROD;
               end
            end
         end
         ST_SQ: begin
            cmd0     = '{start: 1'b1, nbits: CNT_W'(MUL_W)};
            state_in = ST_SQ_WAIT;
         end
         ST_SQ_WAIT: begin
            if (!busy0) begin
               inv_in = res0;
               if (FERMAT_EXP[e_ff]) begin
                  state_in = ST_MUL;
               end else if (e_ff == '0) begin
                  state_in = ST_FIN;
               end else begin
                  e_in     = e_ff - 1'b1;
                  state_in = ST_SQ;
               end
            end
         end
         ST_MUL: begin
            cmd0     = '{start: 1'b1, nbits: CNT_W'(MUL_W)};
            b0       = den_ff;
            state_in = ST_MUL_WAIT;
         end
         ST_MUL_WAIT: begin
            if (!busy0) begin
               inv_in = res0;
               if (e_ff == '0) begin
                  state_in = ST_FIN;
               end else begin
                  e_in     = e_ff - 1'b1;
                  state_in = ST_SQ;
               end
            end
         end
         ST_FIN: begin
            cmd0     = '{start: 1'b1, nbits: CNT_W'(MUL_W)};
            a0       = num_ff;
            state_in = ST_FIN_WAIT;
         end
         ST_FIN_WAIT: begin
            if (!busy0) begin
               num_in   = res0;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // Hand the count to the output register once it is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = num_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      k_ff         <= k_in;
      j_ff         <= j_in;
      e_ff         <= e_in;
      num_ff       <= num_in;
      den_ff       <= den_in;
      inv_ff       <= inv_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign req_ready          = (state_ff == ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_sequence_count = rsp_count_ff;

   // Count is a reduced residue whenever the response is valid
   a_count_reduced: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_sequence_count < PRIME_MOD))
      else $error("response count not below modulus");

   // An accepted request occupies the block
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted twice in a row");

   // Multipliers stay quiet while no request is in flight
   a_mul_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (!busy0 && !busy1))
      else $error("multiplier busy while idle");

   // A new response is only loaded from the done state
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> ($past(state_ff) == ST_DONE))
      else $error("response raised outside done state");

endmodule
